// ===== design/dbnc_pkg.sv =====
package dbnc_pkg;

   localparam int PIN_W      = 7;
   localparam int CH_W       = 3;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_CAPTURE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH0 = 3'd1;

   localparam logic [PIN_W-1:0]   MASK_RESET   = '1;
   localparam logic [COUNT_W-1:0] THRESH_RESET = 16'd4;

   typedef struct packed {
      logic               target;
      logic               confirmed;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic emit;
      logic active;
   } event_type;

endpackage

// ===== design/multi_channel_integral_debounce.sv =====
// A new request is accepted only after the previous one has updated every channel and
// registered its last response, if it has one; response stalls delay both.
// One channel entry a cycle is read from the state memory and updated while responses are
// not stalled; only entries of enabled channels are written back.
// Reset is synchronous: it clears all channel state, sets the enable mask to all ones
// and every threshold to four.
module multi_channel_integral_debounce #(
   parameter int CHANNELS = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [dbnc_pkg::PIN_W-1:0]         req_pin_levels,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dbnc_pkg::CH_W-1:0]          rsp_channel,
   output logic                               rsp_active,
   output logic                               rsp_last,
   input  logic                               csr_write,
   input  logic [dbnc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dbnc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dbnc_pkg::*;

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [ADDR_W-1:0] LAST_CH = ADDR_W'(CHANNELS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [CHANNELS-1:0] pins_ff, pins_in;
   logic [PIN_W-1:0]    mask_ff;
   logic [COUNT_W-1:0]  thresh_ff [CHANNELS];

   logic                rd_on_ff, rd_on_in;
   logic [ADDR_W-1:0]   rd_ch_ff, rd_ch_in;
   logic                b_valid_ff, b_valid_in;
   logic [ADDR_W-1:0]   b_ch_ff, b_ch_in;

   logic                pend_valid_ff, pend_valid_in;
   logic [CH_W-1:0]     pend_ch_ff, pend_ch_in;
   logic                pend_active_ff, pend_active_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]     rsp_ch_ff, rsp_ch_in;
   logic                rsp_active_ff, rsp_active_in;
   logic                rsp_last_ff, rsp_last_in;

   entry_type           cur_entry;
   entry_type           nxt_entry;
   event_type           evt;

   logic                accept;
   logic                out_free;
   logic                b_en;
   logic                b_emit;
   logic                advance;
   logic                mem_rd_en;
   logic                mem_wr_en;
   logic                push;
   logic                flush;

   dbnc_state_mem #(
      .CHANNELS (CHANNELS),
      .ADDR_W   (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_ch_ff),
      .rd_data (cur_entry),
      .wr_en   (mem_wr_en),
      .wr_addr (b_ch_ff),
      .wr_data (nxt_entry)
   );

   dbnc_update u_update (
      .command    (cmd_ff),
      .raw_active (~pins_ff[b_ch_ff]),
      .threshold  (thresh_ff[b_ch_ff]),
      .cur        (cur_entry),
      .nxt        (nxt_entry),
      .evt        (evt)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign b_en      = mask_ff[b_ch_ff];
   assign b_emit    = b_valid_ff && b_en && evt.emit;
   assign advance   = !(b_emit && pend_valid_ff && !out_free);
   assign mem_rd_en = rd_on_ff && advance;
   assign mem_wr_en = b_valid_ff && b_en && advance;
   assign push      = b_emit && pend_valid_ff && advance;
   assign flush     = (state_ff == ST_DRAIN) && pend_valid_ff && out_free;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      pins_in        = pins_ff;
      rd_on_in       = rd_on_ff;
      rd_ch_in       = rd_ch_ff;
      b_valid_in     = b_valid_ff;
      b_ch_in        = b_ch_ff;
      pend_valid_in  = pend_valid_ff;
      pend_ch_in     = pend_ch_ff;
      pend_active_in = pend_active_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cmd_in   = req_command;
               pins_in  = req_pin_levels[CHANNELS-1:0];
               rd_on_in = 1'b1;
               rd_ch_in = '0;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               b_valid_in = rd_on_ff;
               b_ch_in    = rd_ch_ff;
               if (rd_on_ff) begin
                  if (rd_ch_ff == LAST_CH) begin
                     rd_on_in = 1'b0;
                  end else begin
                     rd_ch_in = rd_ch_ff + ADDR_W'(1);
                  end
               end
               if (b_emit) begin
                  pend_valid_in  = 1'b1;
                  pend_ch_in     = CH_W'(b_ch_ff);
                  pend_active_in = evt.active;
               end
            end
            if (!rd_on_ff && !b_valid_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pend_valid_ff || out_free) begin
               state_in      = ST_IDLE;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ch_in     = rsp_ch_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in   = rsp_last_ff;
      if (push || flush) begin
         rsp_valid_in  = 1'b1;
         rsp_ch_in     = pend_ch_ff;
         rsp_active_in = pend_active_ff;
         rsp_last_in   = flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_on_ff      <= 1'b0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_on_ff      <= rd_on_in;
         b_valid_ff    <= b_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      pins_ff        <= pins_in;
      rd_ch_ff       <= rd_ch_in;
      b_ch_ff        <= b_ch_in;
      pend_ch_ff     <= pend_ch_in;
      pend_active_ff <= pend_active_in;
      rsp_ch_ff      <= rsp_ch_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            thresh_ff[i] <= THRESH_RESET;
         end
      end else if (csr_write) begin
         if (csr_index == CSR_ENABLE) begin
            mask_ff <= csr_wdata[PIN_W-1:0];
         end
         for (int i = 0; i < CHANNELS; i++) begin
            if (csr_index == CSR_IDX_W'(CSR_THRESH0 + i)) begin
               thresh_ff[i] <= csr_wdata[COUNT_W-1:0];
            end
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = rsp_ch_ff;
   assign rsp_active  = rsp_active_ff;
   assign rsp_last    = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a channel scan");

   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (state_ff == ST_SCAN))
      else $error("channel update outside of a scan");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_valid_ff && !b_valid_ff && !rd_on_ff))
      else $error("idle with work still in flight");

   assert property (@(posedge clock) disable iff (reset)
      flush |-> (!b_valid_ff && !rd_on_ff))
      else $error("final response sent before all channels were updated");

endmodule

// ===== design/dbnc_state_mem.sv =====
module dbnc_state_mem #(
   parameter int CHANNELS = 7,
   parameter int ADDR_W   = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output dbnc_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  dbnc_pkg::entry_type wr_data
);
   import dbnc_pkg::*;

   entry_type             mem [CHANNELS];
   logic [CHANNELS-1:0]   valid_ff;
   logic [CHANNELS-1:0]   valid_in;
   entry_type             rd_data_ff;
   logic                  rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== design/dbnc_update.sv =====
module dbnc_update (
   input  logic                              command,
   input  logic                              raw_active,
   input  logic [dbnc_pkg::COUNT_W-1:0]      threshold,
   input  dbnc_pkg::entry_type               cur,
   output dbnc_pkg::entry_type               nxt,
   output dbnc_pkg::event_type               evt
);
   import dbnc_pkg::*;

   logic [COUNT_W-1:0] thr;
   entry_type          tick;

   assign thr = (threshold == '0) ? COUNT_W'(1) : threshold;

   always_comb begin
      tick = cur;
      if (raw_active == cur.target) begin
         if (cur.count < thr) begin
            tick.count = cur.count + COUNT_W'(1);
         end
      end else begin
         tick.count  = '0;
         tick.target = raw_active;
      end
      evt.emit   = 1'b0;
      evt.active = tick.target;
      if (tick.count >= thr && tick.confirmed != tick.target) begin
         tick.confirmed = tick.target;
         evt.emit       = 1'b1;
      end
      nxt = tick;
      if (command == CMD_CAPTURE) begin
         nxt.target    = raw_active;
         nxt.confirmed = raw_active;
         nxt.count     = '0;
         evt.emit      = 1'b1;
         evt.active    = raw_active;
      end
   end

endmodule
